FILE: sv/csv_pkg.sv
`default_nettype none
package csv_pkg;

    // Separator slots present in hardware and in the register map
    localparam int SEPARATOR_SLOTS = 4;
    localparam int REG_SLOTS       = 4;

    localparam logic [7:0] QUOTE_CHAR = 8'd34;

    // Register indexes (byte address is 4 * index)
    localparam logic [2:0] REG_SEP_A     = 3'd0;
    localparam logic [2:0] REG_SEP_B     = 3'd1;
    localparam logic [2:0] REG_SEP_C     = 3'd2;
    localparam logic [2:0] REG_SEP_D     = 3'd3;
    localparam logic [2:0] REG_SEP_COUNT = 3'd4;

    localparam logic [7:0] SEP_A_RESET     = 8'd44;
    localparam logic [7:0] SEP_OTHER_RESET = 8'd0;
    localparam logic [2:0] SEP_COUNT_RESET = 3'd1;

    typedef enum logic [2:0] {
        MODE_START  = 3'd0,
        MODE_PLAIN  = 3'd1,
        MODE_QUOTED = 3'd2,
        MODE_QSEEN  = 3'd3
    } parse_mode_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       line_last;
    } csv_in_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_data;
        logic       field_end;
        logic       line_end;
    } csv_out_t;

    typedef struct packed {
        logic [REG_SLOTS-1:0][7:0] chars;
        logic [2:0]                count;
    } sep_cfg_t;

    // Up to two results for one item, in delivery order
    typedef struct packed {
        csv_out_t   first;
        csv_out_t   second;
        logic [1:0] count;
    } csv_dec_t;

endpackage
`default_nettype wire

FILE: sv/csv_cfg_regs.sv
`default_nettype none
module csv_cfg_regs (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [4:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    output csv_pkg::sep_cfg_t      sep_cfg
);

    logic [csv_pkg::REG_SLOTS-1:0][7:0] sep_reg;
    logic [2:0]                         count_reg;
    logic [2:0]                         reg_index;
    logic                               wr_en;

    assign reg_index = paddr[4:2];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg[0] <= csv_pkg::SEP_A_RESET;
            sep_reg[1] <= csv_pkg::SEP_OTHER_RESET;
            sep_reg[2] <= csv_pkg::SEP_OTHER_RESET;
            sep_reg[3] <= csv_pkg::SEP_OTHER_RESET;
            count_reg  <= csv_pkg::SEP_COUNT_RESET;
        end
        else if (wr_en)
        begin
            case (reg_index)
                csv_pkg::REG_SEP_A:     sep_reg[0] <= pwdata[7:0];
                csv_pkg::REG_SEP_B:     sep_reg[1] <= pwdata[7:0];
                csv_pkg::REG_SEP_C:     sep_reg[2] <= pwdata[7:0];
                csv_pkg::REG_SEP_D:     sep_reg[3] <= pwdata[7:0];
                csv_pkg::REG_SEP_COUNT: count_reg  <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            csv_pkg::REG_SEP_A:     prdata = {24'd0, sep_reg[0]};
            csv_pkg::REG_SEP_B:     prdata = {24'd0, sep_reg[1]};
            csv_pkg::REG_SEP_C:     prdata = {24'd0, sep_reg[2]};
            csv_pkg::REG_SEP_D:     prdata = {24'd0, sep_reg[3]};
            csv_pkg::REG_SEP_COUNT: prdata = {29'd0, count_reg};
            default:                prdata = 32'd0;
        endcase
    end

    assign sep_cfg.chars = sep_reg;
    assign sep_cfg.count = count_reg;

endmodule
`default_nettype wire

FILE: sv/csv_parse_core.sv
`default_nettype none
module csv_parse_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire csv_pkg::csv_in_t  in_item,
    input  wire csv_pkg::sep_cfg_t sep_cfg,
    input  wire logic              load_ok,
    output logic                   dec_valid,
    output csv_pkg::csv_dec_t      dec
);

    logic                  hold_valid_reg;
    csv_pkg::csv_in_t      hold_item_reg;
    csv_pkg::parse_mode_t  mode_reg;
    csv_pkg::parse_mode_t  mode_next;
    logic                  advance;
    logic                  is_sep;
    logic                  is_quote;
    logic [7:0]            c;
    logic                  last;
    csv_pkg::csv_out_t     sep_end;
    csv_pkg::csv_out_t     empty_last;
    csv_pkg::csv_out_t     data_out;

    assign advance   = hold_valid_reg && load_ok;
    assign in_stall  = hold_valid_reg && !load_ok;
    assign dec_valid = hold_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            hold_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            hold_item_reg <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= csv_pkg::MODE_START;
        end
        else if (advance)
        begin
            mode_reg <= mode_next;
        end
    end

    assign c        = hold_item_reg.char_code;
    assign last     = hold_item_reg.line_last;
    assign is_quote = (c == csv_pkg::QUOTE_CHAR);

    // Match against the enabled slots only
    always_comb
    begin
        is_sep = 1'b0;
        for (int i = 0; i < csv_pkg::REG_SLOTS; i++)
        begin
            if ((i < csv_pkg::SEPARATOR_SLOTS) && (sep_cfg.count > 3'(i))
                && (sep_cfg.chars[i] == c))
            begin
                is_sep = 1'b1;
            end
        end
    end

    assign sep_end    = '{data_byte: 8'd0, has_data: 1'b0, field_end: 1'b1, line_end: 1'b0};
    assign empty_last = '{data_byte: 8'd0, has_data: 1'b0, field_end: 1'b1, line_end: 1'b1};
    assign data_out   = '{data_byte: c, has_data: 1'b1, field_end: last, line_end: last};

    always_comb
    begin
        dec.first  = data_out;
        dec.second = empty_last;
        dec.count  = 2'd1;
        mode_next  = csv_pkg::MODE_START;
        case (mode_reg)
            csv_pkg::MODE_PLAIN:
            begin
                if (is_sep)
                begin
                    dec.first = sep_end;
                    dec.count = last ? 2'd2 : 2'd1;
                end
                else
                begin
                    mode_next = last ? csv_pkg::MODE_START : csv_pkg::MODE_PLAIN;
                end
            end
            csv_pkg::MODE_QUOTED:
            begin
                if (is_quote)
                begin
                    // Closing quote on the last character ends the field with an empty result
                    dec.first = empty_last;
                    dec.count = last ? 2'd1 : 2'd0;
                    mode_next = last ? csv_pkg::MODE_START : csv_pkg::MODE_QSEEN;
                end
                else
                begin
                    mode_next = last ? csv_pkg::MODE_START : csv_pkg::MODE_QUOTED;
                end
            end
            csv_pkg::MODE_QSEEN:
            begin
                if (is_quote)
                begin
                    mode_next = last ? csv_pkg::MODE_START : csv_pkg::MODE_QUOTED;
                end
                else if (is_sep)
                begin
                    dec.first = sep_end;
                    dec.count = last ? 2'd2 : 2'd1;
                end
                else
                begin
                    mode_next = last ? csv_pkg::MODE_START : csv_pkg::MODE_PLAIN;
                end
            end
            default:
            begin
                if (is_quote)
                begin
                    dec.first = empty_last;
                    dec.count = last ? 2'd1 : 2'd0;
                    mode_next = last ? csv_pkg::MODE_START : csv_pkg::MODE_QUOTED;
                end
                else if (is_sep)
                begin
                    dec.first = sep_end;
                    dec.count = last ? 2'd2 : 2'd1;
                end
                else
                begin
                    mode_next = last ? csv_pkg::MODE_START : csv_pkg::MODE_PLAIN;
                end
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: sv/csv_out_buf.sv
`default_nettype none
module csv_out_buf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              dec_valid,
    input  wire csv_pkg::csv_dec_t dec,
    output logic                   load_ok,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output csv_pkg::csv_out_t      out_item
);

    logic [1:0]        cnt_reg;
    logic [1:0]        cnt_next;
    csv_pkg::csv_out_t slot0_reg;
    csv_pkg::csv_out_t slot0_next;
    csv_pkg::csv_out_t slot1_reg;
    csv_pkg::csv_out_t slot1_next;
    logic              pop;
    logic              load;

    assign out_valid = (cnt_reg != 2'd0);
    assign out_item  = slot0_reg;
    assign pop       = out_valid && !out_stall;
    assign load_ok   = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop);
    assign load      = dec_valid && load_ok;

    always_comb
    begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (load)
        begin
            cnt_next   = dec.count;
            slot0_next = dec.first;
            slot1_next = dec.second;
        end
        else if (pop)
        begin
            cnt_next   = cnt_reg - 2'd1;
            slot0_next = slot1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule
`default_nettype wire

FILE: sv/csv_field_splitter.sv
`default_nettype none
// CSV field splitter: takes one character of a line per item (line_last marks
// the final character) and delivers the unescaped characters of each field,
// with field_end on the last result of a field and line_end on the last result
// of a line. Up to four separator characters are set over the APB port
// (separator_count selects how many, from the first); a quote opening a field
// makes separators literal until the closing quote, and a doubled quote gives
// one quote. An item passes an input register and a result register; the block
// takes one item per cycle while out_stall is low and no second result waits.
// A separator on the last character yields two results; the two-entry result
// register holds both and the input side stalls until the second is delivered.
// An opening or closing quote that is not on the last character yields no result.
module csv_field_splitter (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // input item channel
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire csv_pkg::csv_in_t  in_item,
    // result item channel
    output logic                   out_valid,
    input  wire logic              out_stall,
    output csv_pkg::csv_out_t      out_item,
    // configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [4:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    csv_pkg::sep_cfg_t sep_cfg;
    csv_pkg::csv_dec_t dec;
    logic              dec_valid;
    logic              load_ok;

    // Separator registers
    csv_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .sep_cfg (sep_cfg)
    );

    // Input register, parse mode and per-character decode
    csv_parse_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .sep_cfg   (sep_cfg),
        .load_ok   (load_ok),
        .dec_valid (dec_valid),
        .dec       (dec)
    );

    // Two-entry result register; drains one item per accepted cycle
    csv_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .dec_valid (dec_valid),
        .dec       (dec),
        .load_ok   (load_ok),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule
`default_nettype wire
